### sv/bdq_pkg.sv
package bdq_pkg;

    localparam int KIND_W     = 3;
    localparam int VALUE_W    = 32;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int OUT_DATA_W = 40;

    typedef enum logic [KIND_W-1:0] {
        K_PUSH_FRONT = 3'd0,
        K_PUSH_BACK  = 3'd1,
        K_POP_FRONT  = 3'd2,
        K_POP_BACK   = 3'd3,
        K_REVERSE    = 3'd4,
        K_LIST_FWD   = 3'd5,
        K_LIST_BWD   = 3'd6
    } kind_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RD_POP   = 2'd0,
        RD_FIRST = 2'd1,
        RD_NEXT  = 2'd2
    } rd_sel_t;

    typedef struct packed {
        logic    load;
        logic    push;
        logic    rd;
        rd_sel_t rd_sel;
        logic    pop_commit;
        logic    flip;
        logic    emit;
        logic    emit_mem;
        status_t emit_status;
        logic    emit_last;
    } cmd_t;

    typedef struct packed {
        kind_t kind;
        logic  empty;
        logic  full;
        logic  list_last;
        logic  out_free;
    } stat_t;

endpackage

### sv/bdq_ctrl.sv
module bdq_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  bdq_pkg::stat_t stat,
    output bdq_pkg::cmd_t  cmd
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_EXEC = 4'b0010,
        S_POP  = 4'b0100,
        S_LIST = 4'b1000
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        cmd             = '0;
        cmd.rd_sel      = bdq_pkg::RD_POP;
        cmd.emit_status = bdq_pkg::ST_OK;
        cmd.emit_last   = 1'b1;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                unique case (stat.kind) inside
                    bdq_pkg::K_PUSH_FRONT, bdq_pkg::K_PUSH_BACK:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit = 1'b1;
                            if (stat.full)
                            begin
                                cmd.emit_status = bdq_pkg::ST_FULL;
                            end
                            else
                            begin
                                cmd.push = 1'b1;
                            end
                            state_next = S_IDLE;
                        end
                    end
                    bdq_pkg::K_POP_FRONT, bdq_pkg::K_POP_BACK:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = bdq_pkg::ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd     = 1'b1;
                            cmd.rd_sel = bdq_pkg::RD_POP;
                            state_next = S_POP;
                        end
                    end
                    bdq_pkg::K_REVERSE:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.flip   = 1'b1;
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                    bdq_pkg::K_LIST_FWD, bdq_pkg::K_LIST_BWD:
                    begin
                        if (stat.empty)
                        begin
                            if (stat.out_free)
                            begin
                                cmd.emit        = 1'b1;
                                cmd.emit_status = bdq_pkg::ST_EMPTY;
                                state_next      = S_IDLE;
                            end
                        end
                        else
                        begin
                            cmd.rd     = 1'b1;
                            cmd.rd_sel = bdq_pkg::RD_FIRST;
                            state_next = S_LIST;
                        end
                    end
                    default:
                    begin
                        if (stat.out_free)
                        begin
                            cmd.emit   = 1'b1;
                            state_next = S_IDLE;
                        end
                    end
                endcase
            end
            S_POP:
            begin
                if (stat.out_free)
                begin
                    cmd.pop_commit = 1'b1;
                    cmd.emit       = 1'b1;
                    cmd.emit_mem   = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            S_LIST:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_mem  = 1'b1;
                    cmd.emit_last = stat.list_last;
                    if (stat.list_last)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        // fetch the next entry while this one leaves
                        cmd.rd     = 1'b1;
                        cmd.rd_sel = bdq_pkg::RD_NEXT;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

### sv/bdq_dp.sv
module bdq_dp #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  bdq_pkg::cmd_t                      cmd,
    output bdq_pkg::stat_t                     stat,
    input  logic [bdq_pkg::KIND_W-1:0]         in_kind,
    input  logic [bdq_pkg::VALUE_W-1:0]        in_value,
    input  logic                               out_ready,
    output logic                               out_valid,
    output logic [bdq_pkg::OUT_DATA_W-1:0]     out_data,
    output logic                               out_last
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);

    bdq_pkg::kind_t          kind_reg;
    logic [DATA_WIDTH-1:0]   value_reg;
    logic [AW-1:0]           front_reg, front_next;
    logic [CW-1:0]           count_reg, count_next;
    logic                    rev_reg, rev_next;
    logic [AW-1:0]           idx_reg, idx_next;

    logic [DATA_WIDTH-1:0]   mem [DEPTH];
    logic [DATA_WIDTH-1:0]   rd_data_reg;

    logic                          out_valid_reg;
    logic [bdq_pkg::VALUE_W-1:0]   out_value_reg;
    bdq_pkg::status_t              out_status_reg;
    logic [bdq_pkg::COUNT_W-1:0]   out_count_reg;
    logic                          out_last_reg;

    logic                push_head, pop_head, list_fwd, out_free;
    logic [AW-1:0]       last_off, front_dec, front_inc, list_off, rd_off;
    logic [AW-1:0]       rd_addr, wr_addr;
    logic [CW-1:0]       list_pos;
    logic signed [bdq_pkg::VALUE_W-1:0] rd_ext;

    function automatic logic [AW-1:0] wrap_add(input logic [AW-1:0] a, input logic [AW-1:0] b);
        logic [AW:0] sum;
        sum = {1'b0, a} + {1'b0, b};
        if (sum >= DEPTH_W)
        begin
            sum = sum - DEPTH_W;
        end
        return sum[AW-1:0];
    endfunction

    assign out_free  = !out_valid_reg || out_ready;
    assign push_head = (kind_reg == bdq_pkg::K_PUSH_FRONT) != rev_reg;
    assign pop_head  = (kind_reg == bdq_pkg::K_POP_FRONT) != rev_reg;
    assign list_fwd  = (kind_reg == bdq_pkg::K_LIST_FWD) != rev_reg;

    assign last_off  = AW'(count_reg - CW'(1));
    assign front_dec = wrap_add(front_reg, AW'(DEPTH - 1));
    assign front_inc = wrap_add(front_reg, AW'(1));
    assign list_pos  = (cmd.rd_sel == bdq_pkg::RD_NEXT) ? CW'(idx_reg) + CW'(1) : '0;
    assign list_off  = list_fwd ? AW'(list_pos) : AW'(count_reg - CW'(1) - list_pos);

    always_comb
    begin
        unique case (cmd.rd_sel)
            bdq_pkg::RD_POP: rd_off = pop_head ? '0 : last_off;
            default:         rd_off = list_off;
        endcase
    end

    assign rd_addr = wrap_add(front_reg, rd_off);
    // count stays below DEPTH on a push, so the cut is safe
    assign wr_addr = push_head ? front_dec : wrap_add(front_reg, AW'(count_reg));

    always_comb
    begin
        front_next = front_reg;
        count_next = count_reg;
        rev_next   = rev_reg;
        idx_next   = idx_reg;
        if (cmd.push)
        begin
            count_next = count_reg + CW'(1);
            if (push_head)
            begin
                front_next = front_dec;
            end
        end
        if (cmd.pop_commit)
        begin
            count_next = count_reg - CW'(1);
            if (pop_head)
            begin
                front_next = front_inc;
            end
        end
        if (cmd.flip)
        begin
            rev_next = !rev_reg;
        end
        if (cmd.rd)
        begin
            idx_next = AW'(list_pos);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            front_reg <= front_next;
            count_reg <= count_next;
            rev_reg   <= rev_next;
            idx_reg   <= idx_next;
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the beat payload until the controller asks for the next one
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            kind_reg  <= bdq_pkg::kind_t'(in_kind);
            value_reg <= DATA_WIDTH'(in_value);
        end
        if (cmd.emit)
        begin
            out_value_reg  <= cmd.emit_mem ? rd_ext : '0;
            out_status_reg <= cmd.emit_status;
            out_count_reg  <= bdq_pkg::COUNT_W'(count_next);
            out_last_reg   <= cmd.emit_last;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            mem[wr_addr] <= value_reg;
        end
        if (cmd.rd)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_ext = bdq_pkg::VALUE_W'(signed'(rd_data_reg));

    assign stat.kind      = kind_reg;
    assign stat.empty     = (count_reg == '0);
    assign stat.full      = (count_reg == CW'(DEPTH));
    assign stat.list_last = (CW'(idx_reg) + CW'(1) == count_reg);
    assign stat.out_free  = out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = {1'b0, out_count_reg, out_status_reg, out_value_reg};
    assign out_last  = out_last_reg;

endmodule

### sv/bounded_deque_with_reverse.sv
// A push, reverse or rejected operation puts its beat in the output register
// in the execute state, a pop in the pop state after its read of the entry
// store, and a listing its entries in the list state, one read ahead, through
// the single store read port. No new operation is taken until the last emits.
// Reset (rst_n low, asynchronous) empties the queue and clears the direction
// flag; store contents are undefined until written.
module bounded_deque_with_reverse #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    input  logic [bdq_pkg::VALUE_W-1:0]        s_tdata,   // [31:0] value
    input  logic [bdq_pkg::KIND_W-1:0]         s_tuser,   // [2:0] kind
    output logic                               m_tvalid,
    input  logic                               m_tready,
    output logic [bdq_pkg::OUT_DATA_W-1:0]     m_tdata,   // [31:0] value_out, [33:32] status,
                                                          // [38:34] count, [39] zero
    output logic                               m_tlast    // last
);

    bdq_pkg::cmd_t  cmd;
    bdq_pkg::stat_t stat;

    bdq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    bdq_dp #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .in_kind   (s_tuser),
        .in_value  (s_tdata),
        .out_ready (m_tready),
        .out_valid (m_tvalid),
        .out_data  (m_tdata),
        .out_last  (m_tlast)
    );

`ifndef SYNTHESIS
    a_emit_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("result loaded while output register still occupied");

    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.push |-> !stat.full)
        else $error("push written into a full store");

    a_idle_no_emit: assert property (@(posedge clk) disable iff (!rst_n)
        s_tready |-> !cmd.emit && !cmd.rd && !cmd.push)
        else $error("datapath activity while waiting for a beat");

    a_full_zero_value: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tdata[33:32] == 2'(bdq_pkg::ST_FULL)) |-> m_tdata[31:0] == '0)
        else $error("full status carries a nonzero value");
`endif

endmodule

### tb/sv/deque_checker.sv
module deque_checker #(
    parameter int DEPTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           s_tvalid,
    input  logic                           s_tready,
    input  logic [bdq_pkg::VALUE_W-1:0]    s_tdata,
    input  logic [bdq_pkg::KIND_W-1:0]     s_tuser,
    input  logic                           m_tvalid,
    input  logic                           m_tready,
    input  logic [bdq_pkg::OUT_DATA_W-1:0] m_tdata,
    input  logic                           m_tlast,
    output int                             errors,
    output int                             pending
);

    localparam int SLOT_W = $clog2(DEPTH);
    localparam int VW     = bdq_pkg::VALUE_W;
    localparam int SW     = bdq_pkg::STATUS_W;
    localparam int CNT_W  = bdq_pkg::COUNT_W;

    typedef struct packed {
        logic [VW-1:0]    value;
        bdq_pkg::status_t status;
        logic [CNT_W-1:0] count;
        logic             last;
    } result_t;

    // shadow copy of the deque
    logic [VW-1:0]     ring [DEPTH];
    logic [SLOT_W-1:0] head;
    int unsigned       held;
    bit                flipped;
    result_t           want_q [$];

    task automatic report(input string field, input logic [63:0] got,
                          input logic [63:0] want);
        $display("%0t: %s mismatch, got %0h want %0h", $time, field, got, want);
        errors++;
    endtask

    function automatic logic [SLOT_W-1:0] slot_at(input int unsigned offset);
        return SLOT_W'((32'(head) + offset) % DEPTH);
    endfunction

    // physical slot of a position counted from the logical front
    function automatic logic [SLOT_W-1:0] logical_slot(input int unsigned pos);
        return flipped ? slot_at(held - 1 - pos) : slot_at(pos);
    endfunction

    function automatic void expect_result(input logic [VW-1:0] v,
                                          input bdq_pkg::status_t st, input logic lst);
        result_t r;
        r.value  = v;
        r.status = st;
        r.count  = CNT_W'(held);
        r.last   = lst;
        want_q.push_back(r);
    endfunction

    task automatic apply_op(input bdq_pkg::kind_t k, input logic [VW-1:0] v);
        bit            at_head;
        int unsigned   n;
        logic [VW-1:0] got;
        case (k) inside
            bdq_pkg::K_PUSH_FRONT, bdq_pkg::K_PUSH_BACK:
            begin
                if (held >= DEPTH)
                    expect_result('0, bdq_pkg::ST_FULL, 1'b1);
                else
                begin
                    at_head = (k == bdq_pkg::K_PUSH_FRONT) != flipped;
                    if (at_head)
                    begin
                        head       = slot_at(DEPTH - 1);
                        ring[head] = v;
                    end
                    else
                        ring[slot_at(held)] = v;
                    held++;
                    expect_result('0, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::K_POP_FRONT, bdq_pkg::K_POP_BACK:
            begin
                if (held == 0)
                    expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
                else
                begin
                    at_head = (k == bdq_pkg::K_POP_FRONT) != flipped;
                    if (at_head)
                    begin
                        got  = ring[head];
                        head = slot_at(1);
                    end
                    else
                        got = ring[slot_at(held - 1)];
                    held--;
                    expect_result(got, bdq_pkg::ST_OK, 1'b1);
                end
            end
            bdq_pkg::K_REVERSE:
            begin
                flipped = !flipped;
                expect_result('0, bdq_pkg::ST_OK, 1'b1);
            end
            bdq_pkg::K_LIST_FWD, bdq_pkg::K_LIST_BWD:
            begin
                if (held == 0)
                    expect_result('0, bdq_pkg::ST_EMPTY, 1'b1);
                else
                begin
                    n = held;
                    for (int unsigned i = 0; i < n; i++)
                        expect_result(
                            ring[logical_slot((k == bdq_pkg::K_LIST_FWD) ? i : n - 1 - i)],
                            bdq_pkg::ST_OK, i + 1 == n);
                end
            end
            default:
                expect_result('0, bdq_pkg::ST_OK, 1'b1);
        endcase
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        result_t want;
        if (!rst_n)
        begin
            head    = '0;
            held    = 0;
            flipped = 1'b0;
            errors  = 0;
            want_q.delete();
            pending <= 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (want_q.size() == 0)
                    report("unexpected beat", 64'(m_tdata), '0);
                else
                begin
                    want = want_q.pop_front();
                    if (m_tdata[0 +: VW] !== want.value)
                        report("value_out", 64'(m_tdata[0 +: VW]), 64'(want.value));
                    if (m_tdata[VW +: SW] !== want.status)
                        report("status", 64'(m_tdata[VW +: SW]), 64'(want.status));
                    if (m_tdata[VW + SW +: CNT_W] !== want.count)
                        report("count", 64'(m_tdata[VW + SW +: CNT_W]), 64'(want.count));
                    if (m_tlast !== want.last)
                        report("last", 64'(m_tlast), 64'(want.last));
                end
            end
            if (s_tvalid && s_tready)
                apply_op(bdq_pkg::kind_t'(s_tuser), s_tdata);
            pending <= want_q.size();
        end
    end

endmodule

### tb/sv/tb.sv
module tb;

    localparam int DEPTH = 16;
    localparam int LIMIT = 400000;
    localparam int VW    = bdq_pkg::VALUE_W;

    logic                           clk      = 1'b0;
    logic                           rst_n    = 1'b0;
    logic                           s_tvalid = 1'b0;
    logic                           s_tready;
    logic [VW-1:0]                  s_tdata  = '0;
    logic [bdq_pkg::KIND_W-1:0]     s_tuser  = '0;
    logic                           m_tvalid;
    logic                           m_tready = 1'b0;
    logic [bdq_pkg::OUT_DATA_W-1:0] m_tdata;
    logic                           m_tlast;

    int errors;
    int pending;
    int idle_pct  = 0;
    int stall_pct = 0;
    int cycles    = 0;

    int push_mix [4]  = '{95, 60, 5, 50};
    int idle_mix [4]  = '{0, 56, 0, 30};
    int stall_mix [4] = '{0, 0, 56, 30};

    always #5 clk = ~clk;

    bounded_deque_with_reverse #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (VW)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    deque_checker #(
        .DEPTH (DEPTH)
    ) checker_i (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .errors   (errors),
        .pending  (pending)
    );

    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= stall_pct);

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= LIMIT)
        begin
            $display("FAIL");
            $finish;
        end
    end

    task automatic send_item(input bdq_pkg::kind_t k, input logic [VW-1:0] v);
        while ($urandom_range(99) < idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= k;
        s_tdata  <= v;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    // hold off the sender until every expected beat has come back
    task automatic wait_drained();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    function automatic logic [VW-1:0] pick_value();
        case ($urandom_range(9))
            0:       return {1'b0, {(VW-1){1'b1}}};
            1:       return {1'b1, {(VW-1){1'b0}}};
            2:       return '0;
            3:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic bdq_pkg::kind_t pick_kind(input int push_pct);
        int r;
        r = $urandom_range(99);
        if (r < 8)
            return bdq_pkg::K_REVERSE;
        if (r < 18)
            return $urandom_range(1) ? bdq_pkg::K_LIST_FWD : bdq_pkg::K_LIST_BWD;
        if ($urandom_range(99) < push_pct)
            return $urandom_range(1) ? bdq_pkg::K_PUSH_FRONT : bdq_pkg::K_PUSH_BACK;
        return $urandom_range(1) ? bdq_pkg::K_POP_FRONT : bdq_pkg::K_POP_BACK;
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // empty store, then both ends with the flag set and cleared
        send_item(bdq_pkg::K_POP_FRONT, pick_value());
        send_item(bdq_pkg::K_POP_BACK, pick_value());
        send_item(bdq_pkg::K_LIST_FWD, pick_value());
        send_item(bdq_pkg::K_LIST_BWD, pick_value());
        send_item(bdq_pkg::K_REVERSE, '0);
        send_item(bdq_pkg::K_PUSH_FRONT, 32'h7fff_ffff);
        send_item(bdq_pkg::K_PUSH_BACK, 32'h8000_0000);
        send_item(bdq_pkg::K_PUSH_FRONT, 32'hffff_ffff);
        send_item(bdq_pkg::K_PUSH_BACK, 32'h0000_0000);
        send_item(bdq_pkg::K_LIST_FWD, '0);
        send_item(bdq_pkg::K_REVERSE, '0);
        send_item(bdq_pkg::K_LIST_BWD, '0);
        send_item(bdq_pkg::K_POP_FRONT, '0);
        send_item(bdq_pkg::K_POP_BACK, '0);
        // fill up, then push against a full store
        for (int i = 0; i < DEPTH - 2; i++)
            send_item((i % 2) ? bdq_pkg::K_PUSH_BACK : bdq_pkg::K_PUSH_FRONT, $urandom);
        send_item(bdq_pkg::K_PUSH_FRONT, 32'h1234_5678);
        send_item(bdq_pkg::K_PUSH_BACK, 32'h8765_4321);
        send_item(bdq_pkg::K_LIST_FWD, '0);
        send_item(bdq_pkg::K_LIST_BWD, '0);
        wait_drained();

        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct  = idle_mix[ph];
            stall_pct <= stall_mix[ph];
            for (int seg = 0; seg < 4; seg++)
                for (int n = 0; n < 18; n++)
                    send_item(pick_kind(push_mix[seg]), pick_value());
            wait_drained();
        end

        repeat (16) @(posedge clk);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
